### hw/rtl/sm3_pkg.sv
// shared types and constants of the sm3 hash block
package sm3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 61;
  localparam int unsigned RoundW = 6;
  localparam int unsigned IdxW   = 3;

  localparam logic [WordW-1:0] SM3_T_LO = 32'h79CC4519;
  localparam logic [WordW-1:0] SM3_T_HI = 32'h7A879D8A;

  localparam logic [WordW-1:0] SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } sm3_src_t;

  typedef struct packed {
    logic              push;
    sm3_src_t          src;
    logic [1:0]        pad_cnt;
    logic              add_len;
    logic [2:0]        len_add;
    logic              load_work;
    logic              round;
    logic [RoundW-1:0] round_idx;
    logic              fold;
    logic [IdxW-1:0]   out_idx;
    logic              reinit;
  } sm3_cmd_t;

endpackage

### hw/rtl/sm3_dp.sv
// sm3 datapath: message window, round logic, chaining value and length
module sm3_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sm3_pkg::sm3_cmd_t         cmd,
  input  logic [sm3_pkg::WordW-1:0] in_data_word,
  output logic [sm3_pkg::WordW-1:0] digest_word
);
  import sm3_pkg::*;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input logic [4:0] n);
    logic [2*WordW-1:0] d;
    d = {x, x} << n;
    return d[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  logic [WordW-1:0] w_r [16];
  logic [WordW-1:0] cv_r [8];
  logic [WordW-1:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [LenW-1:0]  bytes_r;

  logic [LenW-1:0]  bytes_nxt;
  logic [WordW-1:0] push_word;
  logic [WordW-1:0] exp_word;
  logic [WordW-1:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [WordW-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt, g_nxt, h_nxt;
  logic             early;

  // length sum in bytes
  always_comb begin
    bytes_nxt = bytes_r + {{(LenW-3){1'b0}}, cmd.len_add};
  end

  always_comb begin
    case (cmd.src)
      SRC_DATA:   push_word = in_data_word;
      SRC_PAD: begin
        case (cmd.pad_cnt)
          2'd0:    push_word = 32'h80000000;
          2'd1:    push_word = {in_data_word[31:24], 24'h800000};
          2'd2:    push_word = {in_data_word[31:16], 16'h8000};
          default: push_word = {in_data_word[31:8], 8'h80};
        endcase
      end
      SRC_MARK:   push_word = 32'h80000000;
      SRC_LEN_HI: push_word = bytes_r[LenW-1:LenW-WordW];
      SRC_LEN_LO: push_word = {bytes_r[LenW-WordW-1:0], 3'b000};
      default:    push_word = '0;
    endcase
  end

  // message expansion, one new word per round
  always_comb begin
    exp_word = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  // one compression round
  always_comb begin
    early = (cmd.round_idx[RoundW-1:4] == 2'b00);
    tj    = rotl(early ? SM3_T_LO : SM3_T_HI, cmd.round_idx[4:0]);
    a12   = rotl(a_r, 5'd12);
    ss1   = rotl(a12 + e_r + tj, 5'd7);
    ss2   = ss1 ^ a12;
    if (early) begin
      ff = a_r ^ b_r ^ c_r;
      gg = e_r ^ f_r ^ g_r;
    end else begin
      ff = (a_r & b_r) | (a_r & c_r) | (b_r & c_r);
      gg = (e_r & f_r) | (~e_r & g_r);
    end
    tt1   = ff + d_r + ss2 + (w_r[0] ^ w_r[4]);
    tt2   = gg + h_r + ss1 + w_r[0];
    a_nxt = tt1;
    b_nxt = a_r;
    c_nxt = rotl(b_r, 5'd9);
    d_nxt = c_r;
    e_nxt = perm0(tt2);
    f_nxt = e_r;
    g_nxt = rotl(f_r, 5'd19);
    h_nxt = g_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= cmd.push ? push_word : exp_word;
    end
    if (cmd.load_work) begin
      a_r <= cv_r[0];
      b_r <= cv_r[1];
      c_r <= cv_r[2];
      d_r <= cv_r[3];
      e_r <= cv_r[4];
      f_r <= cv_r[5];
      g_r <= cv_r[6];
      h_r <= cv_r[7];
    end else if (cmd.round) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
      e_r <= e_nxt;
      f_r <= f_nxt;
      g_r <= g_nxt;
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= SM3_IV[i];
      end
      bytes_r <= '0;
    end else begin
      if (cmd.reinit) begin
        for (int i = 0; i < 8; i++) begin
          cv_r[i] <= SM3_IV[i];
        end
        bytes_r <= '0;
      end else begin
        if (cmd.fold) begin
          cv_r[0] <= cv_r[0] ^ a_nxt;
          cv_r[1] <= cv_r[1] ^ b_nxt;
          cv_r[2] <= cv_r[2] ^ c_nxt;
          cv_r[3] <= cv_r[3] ^ d_nxt;
          cv_r[4] <= cv_r[4] ^ e_nxt;
          cv_r[5] <= cv_r[5] ^ f_nxt;
          cv_r[6] <= cv_r[6] ^ g_nxt;
          cv_r[7] <= cv_r[7] ^ h_nxt;
        end
        if (cmd.add_len) begin
          bytes_r <= bytes_nxt;
        end
      end
    end
  end

  assign digest_word = cv_r[cmd.out_idx];

endmodule

### hw/rtl/sm3_ctrl.sv
// sm3 controller: word intake, padding sequence, round count and digest output
module sm3_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_byte_count,
  input  logic                     in_is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [sm3_pkg::IdxW-1:0] out_word_index,
  output logic                     out_last_word,
  output sm3_pkg::sm3_cmd_t        cmd
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN_LO,
    S_ROUND,
    S_EMIT
  } state_t;

  localparam logic [3:0]        FillLast  = 4'd15;
  localparam logic [3:0]        FillLen   = 4'd14;
  localparam logic [RoundW-1:0] RoundLast = '1;
  localparam logic [IdxW-1:0]   IdxLast   = '1;

  state_t            state_r, state_nxt, ret_r, ret_nxt, push_tgt;
  logic [3:0]        fill_r, fill_nxt;
  logic [RoundW-1:0] round_r, round_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [2:0]        cnt;

  always_comb begin
    cnt       = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    cmd       = '0;
    cmd.src   = SRC_ZERO;
    cmd.round_idx = round_r;
    cmd.out_idx   = idx_r;
    push_tgt  = state_r;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fill_nxt  = fill_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.push    = 1'b1;
          cmd.add_len = 1'b1;
          if (!in_is_last) begin
            cmd.src     = SRC_DATA;
            cmd.len_add = 3'd4;
            push_tgt    = S_IDLE;
          end else begin
            cmd.len_add = cnt;
            cmd.pad_cnt = cnt[1:0];
            if (cnt == 3'd4) begin
              cmd.src  = SRC_DATA;
              push_tgt = S_MARK;
            end else begin
              cmd.src  = SRC_PAD;
              push_tgt = S_ZERO;
            end
          end
        end
      end
      S_MARK: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_MARK;
        push_tgt = S_ZERO;
      end
      S_ZERO: begin
        cmd.push = 1'b1;
        if (fill_r == FillLen) begin
          cmd.src  = SRC_LEN_HI;
          push_tgt = S_LEN_LO;
        end else begin
          cmd.src  = SRC_ZERO;
          push_tgt = S_ZERO;
        end
      end
      S_LEN_LO: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN_LO;
        push_tgt = S_EMIT;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        round_nxt = round_r + 1'b1;
        if (round_r == RoundLast) begin
          cmd.fold  = 1'b1;
          state_nxt = ret_r;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IdxLast) begin
            cmd.reinit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a full block starts the rounds, then resumes at the push target
    if (cmd.push) begin
      if (fill_r == FillLast) begin
        fill_nxt      = '0;
        cmd.load_work = 1'b1;
        round_nxt     = '0;
        ret_nxt       = push_tgt;
        state_nxt     = S_ROUND;
      end else begin
        fill_nxt  = fill_r + 4'd1;
        state_nxt = push_tgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      fill_r  <= '0;
      round_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_EMIT);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == IdxLast);

endmodule

### hw/rtl/sm3_hash.sv
// sm3 hash top level: controller and datapath
// SM3 (256-bit digest) over a message fed one big-endian 32-bit word per
// item; byte_count is honored only on the item with is_last set. A word that
// does not complete a 512-bit block is taken without stalling. The sixteenth word
// of a block starts the compression, one round per cycle in a single shared
// round unit, and the input is stalled while the rounds run. After the last
// item the padding words are pushed one a cycle outside the compressions (up
// to 18, with one or two compressions), then the eight digest words come out
// in order, one per accepted output cycle, and the block starts a new message
// from the initial value.
module sm3_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sm3_pkg::*;

  sm3_cmd_t cmd;

  sm3_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_count  (in_byte_count),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .cmd            (cmd)
  );

  sm3_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_word (in_data_word),
    .digest_word  (out_digest_word)
  );

endmodule
